// ----- hw/rtl/bms_pkg.sv -----
// shared types, register codes and saturating helpers for the ball motion step
package bms_pkg;

  localparam int DATA_W      = 32;
  localparam int RADIUS_W    = 7;
  localparam int CFG_DATA_W  = 20;
  localparam int CFG_INDEX_W = 3;
  localparam int MUL_SHIFT   = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_GRAVITY_STEP   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_TIME_STEP      = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_DAMPING        = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_REST_THRESHOLD = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_ARENA_W        = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_ARENA_H        = 3'd5;

  localparam logic [19:0] RST_GRAVITY_STEP   = 20'd32768;
  localparam logic [15:0] RST_TIME_STEP      = 16'd1092;
  localparam logic [16:0] RST_DAMPING        = 17'd65470;
  localparam logic [19:0] RST_REST_THRESHOLD = 20'd3277;
  localparam logic [12:0] RST_ARENA_W        = 13'd1024;
  localparam logic [12:0] RST_ARENA_H        = 13'd768;

  localparam logic signed [33:0] SAT_HI = 34'sd2147483647;
  localparam logic signed [33:0] SAT_LO = -34'sd2147483648;

  typedef struct packed {
    logic signed [DATA_W-1:0] pos_x;
    logic signed [DATA_W-1:0] pos_y;
    logic signed [DATA_W-1:0] vel_x;
    logic signed [DATA_W-1:0] vel_y;
    logic [RADIUS_W-1:0]      radius;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] new_pos_x;
    logic signed [DATA_W-1:0] new_pos_y;
    logic signed [DATA_W-1:0] new_vel_x;
    logic signed [DATA_W-1:0] new_vel_y;
    logic                     hit_side;
    logic                     hit_floor_ceiling;
  } out_item_t;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [33:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > SAT_HI) r = 32'sh7FFFFFFF;
    else if (v < SAT_LO) r = 32'sh80000000;
    else r = $signed(v[DATA_W-1:0]);
    return r;
  endfunction

  // negation where the most negative value maps to the most positive
  function automatic logic signed [DATA_W-1:0] neg_sat32(input logic signed [DATA_W-1:0] v);
    logic signed [33:0] w;
    w = 34'(v);
    return sat32(-w);
  endfunction

  function automatic logic [DATA_W-1:0] mag32(input logic signed [DATA_W-1:0] v);
    logic [DATA_W-1:0] m;
    m = v[DATA_W-1] ? (~v + 32'd1) : v;
    return m;
  endfunction

endpackage

// ----- hw/rtl/bms_ball_if.sv -----
// ball channel: one ball state word per handshake
interface bms_ball_if;
  import bms_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/bms_result_if.sv -----
// result channel: one updated ball word per handshake
interface bms_result_if;
  import bms_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/bms_mul_q16.sv -----
// registered signed by unsigned Q16 multiply, truncated toward zero, saturated
module bms_mul_q16 #(
  parameter int KW = 17
) (
  input  logic                            clk,
  input  logic                            en,
  input  logic signed [bms_pkg::DATA_W-1:0] v,
  input  logic [KW-1:0]                   k,
  output logic signed [bms_pkg::DATA_W-1:0] q
);
  import bms_pkg::*;

  localparam int PW = DATA_W + KW;
  localparam int RW = PW - MUL_SHIFT;

  logic [PW-1:0] prod;
  logic          neg;
  logic [RW-1:0] r;
  logic signed [33:0] rs;

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= {{KW{1'b0}}, mag32(v)} * {{DATA_W{1'b0}}, k};
      neg  <= v[DATA_W-1];
    end
  end

  always_comb begin
    r  = prod[PW-1:MUL_SHIFT];
    rs = $signed(34'(r));
    q  = sat32(neg ? -rs : rs);
  end

endmodule

// ----- hw/rtl/ball_motion_step.sv -----
// ball_motion_step: one Euler step with wall bounce for one ball
//
// Balls enter on the ball channel and leave on the result channel, both
// valid/ready; a word moves at a clock edge where both are high. Each
// ball produces exactly one result word, in order. Configuration is a
// plain write port (cfg_we, cfg_index, cfg_data); the user must write it
// only while idle, and the block itself does not enforce this.
// Throughput: one ball per cycle while the result channel is not stalled;
// the seven register stages a ball passes in order are gravity, damping
// multiply, damping scale and rest test, time step multiply, position
// add, side walls, floor and ceiling. Each velocity lane owns its own two
// multipliers.
//
// Reset (rst, synchronous) empties the pipeline and loads the default
// register values. When the receiver stalls, each stage holds its word
// and only the stages in front of a held word stall, so bubbles fill up
// and ball.ready drops once every stage is occupied.
module ball_motion_step #(
  parameter int FRAC_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  bms_ball_if.sink                           ball,
  bms_result_if.source                       result,
  input  logic                               cfg_we,
  input  logic [bms_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [bms_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import bms_pkg::*;

  localparam int NSTAGE = 7;
  localparam int PIXW   = 33 - FRAC_BITS;
  localparam int CMPW   = (PIXW > 14) ? PIXW + 2 : 16;
  // wide enough for a shifted 14-bit pixel and for the 32-bit bounds
  localparam int WIDEW  = (FRAC_BITS > 19) ? 14 + FRAC_BITS : 33;
  localparam logic [DATA_W-1:0] FRAC_MASK = {{(DATA_W-FRAC_BITS){1'b1}}, {FRAC_BITS{1'b0}}};
  localparam logic signed [DATA_W-1:0] ONE_PIX = $signed(32'd1 << FRAC_BITS);
  localparam logic signed [WIDEW-1:0] W_HI = WIDEW'(32'sh7FFFFFFF);
  localparam logic signed [WIDEW-1:0] W_LO = WIDEW'(32'sh80000000);

  // truncate a coordinate toward zero onto its whole pixel
  function automatic logic signed [DATA_W-1:0] snap(input logic signed [DATA_W-1:0] p);
    logic signed [DATA_W-1:0] c;
    c = p & FRAC_MASK;
    if (p[DATA_W-1] && (p[FRAC_BITS-1:0] != '0)) c = c + ONE_PIX;
    return c;
  endfunction

  function automatic logic signed [PIXW-1:0] to_pix(input logic signed [DATA_W-1:0] p);
    logic signed [DATA_W-1:0] s;
    s = snap(p);
    return $signed({s[DATA_W-1], s[DATA_W-1:FRAC_BITS]});
  endfunction

  function automatic logic signed [DATA_W-1:0] from_pix(input logic signed [13:0] v);
    logic signed [WIDEW-1:0] w;
    logic signed [DATA_W-1:0] r;
    w = WIDEW'(v) <<< FRAC_BITS;
    if (w > W_HI) r = 32'sh7FFFFFFF;
    else if (w < W_LO) r = 32'sh80000000;
    else r = $signed(w[DATA_W-1:0]);
    return r;
  endfunction

  // configuration registers
  logic [19:0] gravity_step;
  logic [15:0] time_step;
  logic [16:0] damping;
  logic [19:0] rest_threshold;
  logic [12:0] arena_w;
  logic [12:0] arena_h;

  always_ff @(posedge clk) begin
    if (rst) begin
      gravity_step   <= RST_GRAVITY_STEP;
      time_step      <= RST_TIME_STEP;
      damping        <= RST_DAMPING;
      rest_threshold <= RST_REST_THRESHOLD;
      arena_w        <= RST_ARENA_W;
      arena_h        <= RST_ARENA_H;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GRAVITY_STEP:   gravity_step   <= cfg_data;
        CFG_TIME_STEP:      time_step      <= cfg_data[15:0];
        CFG_DAMPING:        damping        <= cfg_data[16:0];
        CFG_REST_THRESHOLD: rest_threshold <= cfg_data;
        CFG_ARENA_W:        arena_w        <= cfg_data[12:0];
        CFG_ARENA_H:        arena_h        <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  // pipeline control: a stage loads when empty or when the next one loads
  logic [NSTAGE-1:0] vld;
  logic [NSTAGE-1:0] en;

  always_comb begin
    en[NSTAGE-1] = !vld[NSTAGE-1] || result.ready;
    for (int i = NSTAGE - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign ball.ready   = en[0];
  assign result.valid = vld[NSTAGE-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= ball.valid;
      for (int i = 1; i < NSTAGE; i++) begin
        if (en[i]) vld[i] <= vld[i-1];
      end
    end
  end

  // stage 0: gravity
  logic signed [DATA_W-1:0] s0_px, s0_py, s0_vx, s0_vy;
  logic [RADIUS_W-1:0]      s0_r;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_px <= ball.data.pos_x;
      s0_py <= ball.data.pos_y;
      s0_vx <= ball.data.vel_x;
      s0_vy <= sat32(34'(ball.data.vel_y) - $signed({14'd0, gravity_step}));
      s0_r  <= ball.data.radius;
    end
  end

  // stage 1: damping products
  logic signed [DATA_W-1:0] s1_px, s1_py, dx, dy;
  logic [RADIUS_W-1:0]      s1_r;

  bms_mul_q16 #(.KW(17)) u_damp_x (.clk(clk), .en(en[1]), .v(s0_vx), .k(damping), .q(dx));
  bms_mul_q16 #(.KW(17)) u_damp_y (.clk(clk), .en(en[1]), .v(s0_vy), .k(damping), .q(dy));

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_px <= s0_px;
      s1_py <= s0_py;
      s1_r  <= s0_r;
    end
  end

  // stage 2: damped velocity with rest zeroing
  logic signed [DATA_W-1:0] s2_px, s2_py, s2_vx, s2_vy;
  logic [RADIUS_W-1:0]      s2_r;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_px <= s1_px;
      s2_py <= s1_py;
      s2_vx <= (mag32(dx) < {12'd0, rest_threshold}) ? '0 : dx;
      s2_vy <= (mag32(dy) < {12'd0, rest_threshold}) ? '0 : dy;
      s2_r  <= s1_r;
    end
  end

  // stage 3: velocity times time step
  logic signed [DATA_W-1:0] s3_px, s3_py, s3_vx, s3_vy, tx, ty;
  logic [RADIUS_W-1:0]      s3_r;

  bms_mul_q16 #(.KW(16)) u_step_x (.clk(clk), .en(en[3]), .v(s2_vx), .k(time_step), .q(tx));
  bms_mul_q16 #(.KW(16)) u_step_y (.clk(clk), .en(en[3]), .v(s2_vy), .k(time_step), .q(ty));

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_px <= s2_px;
      s3_py <= s2_py;
      s3_vx <= s2_vx;
      s3_vy <= s2_vy;
      s3_r  <= s2_r;
    end
  end

  // stage 4: position update
  logic signed [DATA_W-1:0] s4_px, s4_py, s4_vx, s4_vy;
  logic [RADIUS_W-1:0]      s4_r;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s4_px <= sat32(34'(s3_px) + 34'(tx));
      s4_py <= sat32(34'(s3_py) + 34'(ty));
      s4_vx <= s3_vx;
      s4_vy <= s3_vy;
      s4_r  <= s3_r;
    end
  end

  // stage 5: left and right walls
  logic signed [CMPW-1:0]   pxc, rc4, wc;
  logic signed [13:0]       r4_14, w_minus_r;
  logic                     hit_left, hit_right;
  logic signed [DATA_W-1:0] s5_px, s5_py, s5_vx, s5_vy;
  logic [RADIUS_W-1:0]      s5_r;
  logic                     s5_hit_side;

  always_comb begin
    pxc       = CMPW'(to_pix(s4_px));
    rc4       = $signed(CMPW'(s4_r));
    wc        = $signed(CMPW'(arena_w));
    r4_14     = $signed(14'(s4_r));
    w_minus_r = $signed({1'b0, arena_w}) - r4_14;
    hit_left  = pxc < rc4;
    hit_right = !hit_left && (pxc + rc4 > wc);
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s5_vy       <= s4_vy;
      s5_r        <= s4_r;
      s5_hit_side <= hit_left || hit_right;
      if (hit_left || hit_right) begin
        s5_px <= hit_left ? from_pix(r4_14) : from_pix(w_minus_r);
        s5_py <= snap(s4_py);
        s5_vx <= neg_sat32(s4_vx);
      end else begin
        s5_px <= s4_px;
        s5_py <= s4_py;
        s5_vx <= s4_vx;
      end
    end
  end

  // stage 6: floor and ceiling, with y measured upward from the floor
  logic signed [CMPW-1:0] pyc, rc5, hc;
  logic signed [13:0]     r5_14, h_minus_r;
  logic                   hit_ceiling, hit_floor;
  out_item_t              out_word;

  always_comb begin
    pyc         = CMPW'(to_pix(s5_py));
    rc5         = $signed(CMPW'(s5_r));
    hc          = $signed(CMPW'(arena_h));
    r5_14       = $signed(14'(s5_r));
    h_minus_r   = $signed({1'b0, arena_h}) - r5_14;
    hit_ceiling = pyc > hc - rc5;
    hit_floor   = !hit_ceiling && (pyc < rc5);
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      out_word.new_vel_x   <= s5_vx;
      out_word.hit_side    <= s5_hit_side;
      out_word.hit_floor_ceiling <= hit_ceiling || hit_floor;
      if (hit_ceiling || hit_floor) begin
        out_word.new_pos_x <= snap(s5_px);
        out_word.new_pos_y <= hit_ceiling ? from_pix(h_minus_r) : from_pix(r5_14);
        out_word.new_vel_y <= neg_sat32(s5_vy);
      end else begin
        out_word.new_pos_x <= s5_px;
        out_word.new_pos_y <= s5_py;
        out_word.new_vel_y <= s5_vy;
      end
    end
  end

  assign result.data = out_word;

`ifndef ASSERT_OFF
  // a floor or ceiling bounce leaves x on a whole pixel
  a_fc_snaps_x: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.data.hit_floor_ceiling
      |-> result.data.new_pos_x[FRAC_BITS-1:0] == '0)
    else $error("x not on whole pixel after floor or ceiling hit");

  // a side bounce alone leaves y on a whole pixel
  a_side_snaps_y: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.data.hit_side && !result.data.hit_floor_ceiling
      |-> result.data.new_pos_y[FRAC_BITS-1:0] == '0)
    else $error("y not on whole pixel after side hit");

  // a word moving into the output stage is there in the next cycle
  a_last_move: assert property (@(posedge clk) disable iff (rst)
    vld[NSTAGE-2] && en[NSTAGE-1] |=> vld[NSTAGE-1])
    else $error("word lost entering output stage");

  // the input is held off only while the first and last stages are occupied and the receiver stalls
  a_ready_full: assert property (@(posedge clk) disable iff (rst)
    !ball.ready |-> vld[0] && vld[NSTAGE-1] && !result.ready)
    else $error("input stalled with room in pipeline");
`endif

endmodule
